// File: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Types, sizes and codes shared by the segment allocator modules.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int SEG_COUNT = 64;
  localparam int SEG_W     = 6;
  localparam int SEG_LOG2  = 20;
  localparam int OFS_W     = 21;
  localparam int ADDR_W    = 26;
  localparam int TOTAL_W   = 21;
  localparam int CNT_W     = 7;

  localparam logic [OFS_W-1:0] SEG_BYTES = OFS_W'(1 << SEG_LOG2);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RECLAIM = 2'd2,
    REQ_REFILL  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_RESERVE = 2'd1,
    ST_NO_SEGMENT = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic place;
    logic walk_rd;
    logic walk_ex;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic in_reclaim;
    logic place_needed;
    logic walk_stop;
    logic rsp_free;
  } sts_t;

endpackage

// File: rtl/lsa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
interface lsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [lsa_pkg::TOTAL_W-1:0]   total;
  logic                          cleanup;
  logic [lsa_pkg::ADDR_W-1:0]    address;

  modport source (output valid, req_type, total, cleanup, address, input ready);
  modport sink   (input valid, req_type, total, cleanup, address, output ready);
endinterface

// File: rtl/lsa_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface lsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [lsa_pkg::ADDR_W-1:0]  item_address;
  logic [lsa_pkg::CNT_W-1:0]   reclaimed_count;
  logic                        reserve_valid;

  modport source (output valid, status, item_address, reclaimed_count, reserve_valid,
                  input ready);
  modport sink   (input valid, status, item_address, reclaimed_count, reserve_valid,
                  output ready);
endinterface

// File: rtl/lsa_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the segment limit register.
// ----------------------------------------------------------------------------
interface lsa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lsa_pkg::CNT_W-1:0]  max_segments;

  modport source (output valid, max_segments, input ready);
  modport sink   (input valid, max_segments, output ready);
endinterface

// File: rtl/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// Segment allocator controller
// Sequences accept, execute, placement, log walk and response steps.
// ----------------------------------------------------------------------------
module lsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lsa_pkg::sts_t sts_i,
  output lsa_pkg::cmd_t cmd_o
);
  import lsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_PLACE   = 6'b000100,
    S_WALK_RD = 6'b001000,
    S_WALK_EX = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_reclaim ? S_WALK_RD : S_EXEC;
        end
      end
      S_EXEC:    state_d = sts_i.place_needed ? S_PLACE : S_RESP;
      S_PLACE:   state_d = S_RESP;
      S_WALK_RD: state_d = sts_i.walk_stop ? S_RESP : S_WALK_EX;
      S_WALK_EX: state_d = S_WALK_RD;
      S_RESP: begin
        if (sts_i.rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec       = (state_q == S_EXEC);
  assign cmd_o.place      = (state_q == S_PLACE);
  assign cmd_o.walk_rd    = (state_q == S_WALK_RD);
  assign cmd_o.walk_ex    = (state_q == S_WALK_EX);
  assign cmd_o.load_rsp   = (state_q == S_RESP) && sts_i.rsp_free;

endmodule

// File: rtl/lsa_datapath.sv
// ----------------------------------------------------------------------------
// Segment allocator datapath
// Segment tables, free stack, log links, allocation arithmetic and result.
// ----------------------------------------------------------------------------
module lsa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsa_pkg::cmd_t                cmd_i,
  output lsa_pkg::sts_t                sts_o,
  input  logic [1:0]                   in_req_type_i,
  input  logic [lsa_pkg::TOTAL_W-1:0]  in_total_i,
  input  logic                         in_cleanup_i,
  input  logic [lsa_pkg::ADDR_W-1:0]   in_address_i,
  input  logic                         cfg_we_i,
  input  logic [lsa_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   out_status_o,
  output logic [lsa_pkg::ADDR_W-1:0]   out_item_address_o,
  output logic [lsa_pkg::CNT_W-1:0]    out_reclaimed_count_o,
  output logic                         out_reserve_valid_o
);
  import lsa_pkg::*;

  function automatic logic [OFS_W:0] sat_add(input logic [OFS_W-1:0] a,
                                             input logic [OFS_W-1:0] b);
    logic [OFS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, SEG_BYTES}) begin
      sat_add = {1'b1, SEG_BYTES};
    end else begin
      sat_add = {1'b0, s[OFS_W-1:0]};
    end
  endfunction

  logic [OFS_W-1:0] fill_mem   [SEG_COUNT];
  logic [OFS_W-1:0] freed_mem  [SEG_COUNT];
  logic [SEG_W-1:0] next_mem   [SEG_COUNT];
  logic [SEG_W-1:0] stack_mem  [SEG_COUNT];

  logic [CNT_W-1:0]   max_seg_q;
  logic [1:0]         req_q;
  logic [TOTAL_W-1:0] total_q;
  logic               cleanup_q;
  logic [SEG_W-1:0]   seg_q;
  logic [SEG_W-1:0]   cur_q, cur_d, head_q, head_d, resv_q, resv_d;
  logic               held_q, held_d;
  logic [CNT_W-1:0]   top_q, top_d, fresh_q, fresh_d;
  logic [SEG_COUNT-1:0] inact_q, inact_d;
  logic [SEG_W-1:0]   ns_q, ns_d, h_q, h_d, prev_q, prev_d;
  logic               took_q, took_d, have_prev_q, have_prev_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  logic [1:0]         st_q, st_d;
  logic [ADDR_W-1:0]  item_q, item_d;
  logic [CNT_W-1:0]   recl_q, recl_d;
  logic               out_valid_q;
  logic [1:0]         out_st_q;
  logic [ADDR_W-1:0]  out_item_q;
  logic [CNT_W-1:0]   out_recl_q;
  logic               out_held_q;

  logic               fill_we, freed_we, next_we, stack_we;
  logic [SEG_W-1:0]   fill_wa, freed_wa, next_wa, stack_wa;
  logic [OFS_W-1:0]   fill_wd, freed_wd;
  logic [SEG_W-1:0]   next_wd, stack_wd;
  logic [SEG_W-1:0]   fill_ra, freed_ra, stack_ra;
  logic [OFS_W-1:0]   fill_rq, freed_rq, fill_rd, freed_rd;
  logic [SEG_W-1:0]   next_rd, stack_rd;
  logic               fill_init0_q, freed_init0_q, fill_z_q, freed_z_q;

  logic [CNT_W-1:0]   limit;
  logic               pop, fresh_ok, pool_ok;
  logic [SEG_W-1:0]   pool_ns;
  logic [OFS_W-1:0]   avail;
  logic [OFS_W:0]     sum_av, sum_fr;
  logic               fits;
  logic               place_needed;

  assign fill_ra  = cur_q;
  assign freed_ra = cmd_i.walk_rd ? h_q :
                    ((in_req_type_i == REQ_FREE) ? in_address_i[ADDR_W-1:SEG_LOG2] : cur_q);
  assign stack_ra = SEG_W'(top_q - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (fill_we)  fill_mem[fill_wa]   <= fill_wd;
    if (freed_we) freed_mem[freed_wa] <= freed_wd;
    if (next_we)  next_mem[next_wa]   <= next_wd;
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    fill_rq  <= fill_mem[fill_ra];
    freed_rq <= freed_mem[freed_ra];
    next_rd  <= next_mem[h_q];
    stack_rd <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_init0_q  <= 1'b0;
      freed_init0_q <= 1'b0;
      fill_z_q      <= 1'b1;
      freed_z_q     <= 1'b1;
    end else begin
      if (fill_we && fill_wa == '0)   fill_init0_q  <= 1'b1;
      if (freed_we && freed_wa == '0) freed_init0_q <= 1'b1;
      fill_z_q  <= (fill_ra == '0) && !fill_init0_q;
      freed_z_q <= (freed_ra == '0) && !freed_init0_q;
    end
  end

  assign fill_rd  = fill_z_q  ? '0 : fill_rq;
  assign freed_rd = freed_z_q ? '0 : freed_rq;

  assign limit    = (max_seg_q > CNT_W'(SEG_COUNT)) ? CNT_W'(SEG_COUNT) : max_seg_q;
  assign pop      = (top_q != '0);
  assign fresh_ok = (fresh_q < limit);
  assign pool_ok  = pop || fresh_ok;
  assign pool_ns  = pop ? stack_rd : fresh_q[SEG_W-1:0];
  assign avail    = SEG_BYTES - fill_rd;
  assign fits     = (avail != '0) && (avail >= total_q);
  assign sum_av   = sat_add(freed_rd, avail);
  assign sum_fr   = sat_add(freed_rd, total_q);

  always_comb begin
    cur_d = cur_q;  head_d = head_q;  resv_d = resv_q;  held_d = held_q;
    top_d = top_q;  fresh_d = fresh_q; inact_d = inact_q;
    ns_d = ns_q;  h_d = h_q;  prev_d = prev_q;  took_d = took_q;
    have_prev_d = have_prev_q;  steps_d = steps_q;
    st_d = st_q;  item_d = item_q;  recl_d = recl_q;
    fill_we = 1'b0;  fill_wa = cur_q;  fill_wd = '0;
    freed_we = 1'b0; freed_wa = cur_q; freed_wd = '0;
    next_we = 1'b0;  next_wa = cur_q;  next_wd = '0;
    stack_we = 1'b0; stack_wa = top_q[SEG_W-1:0]; stack_wd = h_q;
    place_needed = 1'b0;

    if (cmd_i.accept) begin
      st_d = ST_OK;  item_d = '0;  recl_d = '0;
      h_d = head_q;  steps_d = '0;  have_prev_d = 1'b0;
    end

    if (cmd_i.exec) begin
      case (req_q)
        REQ_ALLOC: begin
          if (total_q > SEG_BYTES) begin
            st_d = ST_NO_SEGMENT;
          end else if (!held_q && !cleanup_q) begin
            st_d = ST_NO_RESERVE;
          end else if (fits) begin
            item_d  = {cur_q, fill_rd[SEG_LOG2-1:0]};
            fill_we = 1'b1;
            fill_wd = fill_rd + total_q;
          end else begin
            if (avail != '0) begin
              fill_we  = 1'b1;
              fill_wd  = SEG_BYTES;
              freed_we = 1'b1;
              freed_wd = sum_av[OFS_W-1:0];
            end
            if (pool_ok || (cleanup_q && held_q)) begin
              if (pool_ok) begin
                ns_d   = pool_ns;
                took_d = 1'b1;
                if (pop) top_d = top_q - CNT_W'(1);
                else     fresh_d = fresh_q + CNT_W'(1);
              end else begin
                ns_d   = resv_q;
                took_d = 1'b0;
                held_d = 1'b0;
              end
              next_we = 1'b1;
              next_wd = ns_d;
              inact_d[cur_q] = 1'b1;
              if (pool_ok) inact_d[ns_d] = 1'b0;
              cur_d  = ns_d;
              item_d = {ns_d, {SEG_LOG2{1'b0}}};
              place_needed = 1'b1;
            end else begin
              st_d = ST_NO_SEGMENT;
            end
          end
        end
        REQ_FREE: begin
          if ({1'b0, seg_q} >= fresh_q) begin
            st_d = ST_NO_SEGMENT;
          end else begin
            freed_we = 1'b1;
            freed_wa = seg_q;
            freed_wd = sum_fr[OFS_W-1:0];
            if (sum_fr[OFS_W]) st_d = ST_OVERFLOW;
          end
        end
        REQ_REFILL: begin
          if (!held_q) begin
            if (pool_ok) begin
              if (pop) top_d = top_q - CNT_W'(1);
              else     fresh_d = fresh_q + CNT_W'(1);
              fill_we  = 1'b1;  fill_wa  = pool_ns;
              freed_we = 1'b1;  freed_wa = pool_ns;
              inact_d[pool_ns] = 1'b0;
              resv_d = pool_ns;
              held_d = 1'b1;
            end else begin
              st_d = ST_NO_SEGMENT;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.place) begin
      fill_we = 1'b1;
      fill_wa = ns_q;
      fill_wd = total_q;
      if (took_q) begin
        freed_we = 1'b1;
        freed_wa = ns_q;
      end
    end

    if (cmd_i.walk_ex) begin
      if (freed_rd == SEG_BYTES) begin
        if (!have_prev_q) begin
          head_d = next_rd;
        end else begin
          next_we = 1'b1;
          next_wa = prev_q;
          next_wd = next_rd;
        end
        fill_we = 1'b1;
        fill_wa = h_q;
        if (top_q < CNT_W'(SEG_COUNT)) begin
          stack_we = 1'b1;
          top_d = top_q + CNT_W'(1);
        end
        recl_d = recl_q + CNT_W'(1);
      end else begin
        prev_d = h_q;
        have_prev_d = 1'b1;
      end
      h_d = next_rd;
      steps_d = steps_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q     <= in_req_type_i;
      total_q   <= in_total_i;
      cleanup_q <= in_cleanup_i;
      seg_q     <= in_address_i[ADDR_W-1:SEG_LOG2];
    end
    ns_q <= ns_d;  h_q <= h_d;  prev_q <= prev_d;  took_q <= took_d;
    have_prev_q <= have_prev_d;  steps_q <= steps_d;
    st_q <= st_d;  item_q <= item_d;  recl_q <= recl_d;
    if (cmd_i.load_rsp) begin
      out_st_q   <= st_q;
      out_item_q <= item_q;
      out_recl_q <= recl_q;
      out_held_q <= held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q   <= CNT_W'(SEG_COUNT);
      cur_q       <= '0;
      head_q      <= '0;
      resv_q      <= '0;
      held_q      <= 1'b0;
      top_q       <= '0;
      fresh_q     <= CNT_W'(1);
      inact_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_seg_q <= cfg_data_i;
      cur_q   <= cur_d;
      head_q  <= head_d;
      resv_q  <= resv_d;
      held_q  <= held_d;
      top_q   <= top_d;
      fresh_q <= fresh_d;
      inact_q <= inact_d;
      if (cmd_i.load_rsp)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.place_needed = place_needed;
  assign sts_o.in_reclaim = (in_req_type_i == REQ_RECLAIM);
  assign sts_o.walk_stop  = (h_q == cur_q) || !inact_q[h_q] ||
                            (steps_q == CNT_W'(SEG_COUNT));
  assign sts_o.rsp_free   = !out_valid_q || out_ready_i;

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_st_q;
  assign out_item_address_o    = out_item_q;
  assign out_reclaimed_count_o = out_recl_q;
  assign out_reserve_valid_o   = out_held_q;

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CNT_W'(SEG_COUNT)) else $error("free stack depth out of range");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q >= CNT_W'(1) && fresh_q <= CNT_W'(SEG_COUNT))
    else $error("fresh segment count out of range");
  a_resv_not_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> resv_q != cur_q) else $error("reserve segment is the current segment");

endmodule

// File: rtl/log_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// Log segment allocator core
// Log-structured allocator over fixed-size segments with a free stack.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and each one produces exactly one transaction on
// rsp_o. The segment limit is written on cfg_i, which is always ready. The user
// must see that it is only written while the block is idle; the block itself
// does not enforce this. A request is taken only when the block is idle.
// Free and refill pass through an execute step before the result is loaded;
// an alloc adds a placement step after execution when it opens a new segment.
// A reclaim walks the log with one read step and one update step per segment
// of the walk.
// The result sits in an output register, so a new request is accepted while
// an earlier result still waits; if the receiver stalls, the next result is
// held back until the output register drains.
// Reset brings segment zero into use as the current segment, empties the
// free stack, drops the reserve and sets the segment limit to 64.
// ----------------------------------------------------------------------------
module log_segment_allocator_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  lsa_cfg_if.sink cfg_i,
  lsa_req_if.sink req_i,
  lsa_rsp_if.source rsp_o
);
  import lsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  lsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsa_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .in_req_type_i         (req_i.req_type),
    .in_total_i            (req_i.total),
    .in_cleanup_i          (req_i.cleanup),
    .in_address_i          (req_i.address),
    .cfg_we_i              (cfg_i.valid),
    .cfg_data_i            (cfg_i.max_segments),
    .out_ready_i           (rsp_o.ready),
    .out_valid_o           (rsp_o.valid),
    .out_status_o          (rsp_o.status),
    .out_item_address_o    (rsp_o.item_address),
    .out_reclaimed_count_o (rsp_o.reclaimed_count),
    .out_reserve_valid_o   (rsp_o.reserve_valid)
  );

endmodule
